@@ hw/rtl/kcf_pkg.sv @@
// ----------------------------------------------------------------------------
// kcf_pkg
// Shared types and constants of the keypoint crowding filter.
// ----------------------------------------------------------------------------
package kcf_pkg;

  // Field and datapath widths
  localparam int COORD_W      = 16;
  localparam int DIST_W       = 34;
  localparam int KEPT_COUNT_W = 7;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;

  // Register index, taken from paddr[3] (registers sit 8 bytes apart)
  localparam logic REG_NEAR_RADIUS_SQ  = 1'b0;
  localparam logic REG_CROWD_RADIUS_SQ = 1'b1;

  // Register reset values, 8 fraction bits
  localparam logic [DIST_W-1:0] NEAR_RADIUS_SQ_RST  = 34'd2304;
  localparam logic [DIST_W-1:0] CROWD_RADIUS_SQ_RST = 34'd12544;

  // One pixel squared with 8 fraction bits
  localparam logic [DIST_W-1:0] ONE_PIXEL_SQ = 34'd256;

  // Neighbour limits; counters saturate at these
  localparam logic [1:0] NEAR_LIMIT  = 2'd3;
  localparam logic [3:0] CROWD_LIMIT = 4'd10;

  // One stored survivor
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] age;
  } kept_entry_t;

  // Result of one distance evaluation
  typedef struct packed {
    logic               valid;
    logic [DIST_W-1:0]  sq_dist;
    logic [COORD_W-1:0] age;
  } dist_res_t;

endpackage

@@ hw/rtl/kcf_store.sv @@
// ----------------------------------------------------------------------------
// kcf_store
// Survivor memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kcf_store #(
  parameter int  MAX_POINTS = 64,
  localparam int IDX_W      = $clog2(MAX_POINTS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  kcf_pkg::kept_entry_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  input  logic                 flush_i,
  output kcf_pkg::kept_entry_t rd_data_o,
  output logic                 rd_valid_o
);
  import kcf_pkg::*;

  kept_entry_t mem_q [MAX_POINTS];
  kept_entry_t rd_data_q;
  logic        rd_valid_q;

  // Memory array, written and read in the same clocked block
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Read valid follows the read enable, dropped on flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= rd_en_i && !flush_i;
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

@@ hw/rtl/kcf_dist_unit.sv @@
// ----------------------------------------------------------------------------
// kcf_dist_unit
// Shared squared-distance unit: absolute difference, square, sum, each
// registered; one evaluation enters per cycle.
// ----------------------------------------------------------------------------
module kcf_dist_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          flush_i,
  input  logic                          valid_i,
  input  logic [kcf_pkg::COORD_W-1:0]   ref_x_i,
  input  logic [kcf_pkg::COORD_W-1:0]   ref_y_i,
  input  kcf_pkg::kept_entry_t          entry_i,
  output kcf_pkg::dist_res_t            res_o
);
  import kcf_pkg::*;

  localparam int SQ_W = 2 * COORD_W;

  logic [COORD_W-1:0] dx_d, dy_d;
  logic [COORD_W-1:0] dx_q, dy_q, age1_q;
  logic               v1_q;
  logic [SQ_W-1:0]    sqx_d, sqy_d;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [COORD_W-1:0] age2_q;
  logic               v2_q;
  logic [DIST_W-1:0]  dist_d;
  logic [DIST_W-1:0]  dist_q;
  logic [COORD_W-1:0] age3_q;
  logic               v3_q;

  // Stage 1: absolute differences
  assign dx_d = (ref_x_i > entry_i.x) ? (ref_x_i - entry_i.x) : (entry_i.x - ref_x_i);
  assign dy_d = (ref_y_i > entry_i.y) ? (ref_y_i - entry_i.y) : (entry_i.y - ref_y_i);

  // Stage 2: squares
  assign sqx_d = SQ_W'(dx_q) * SQ_W'(dx_q);
  assign sqy_d = SQ_W'(dy_q) * SQ_W'(dy_q);

  // Stage 3: sum, exact in 34 bits
  assign dist_d = DIST_W'(sqx_q) + DIST_W'(sqy_q);

  // Payload stages
  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    age1_q <= entry_i.age;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    age2_q <= age1_q;
    dist_q <= dist_d;
    age3_q <= age2_q;
  end

  // Valid pipe, cleared on flush
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i && !flush_i;
      v2_q <= v1_q && !flush_i;
      v3_q <= v2_q && !flush_i;
    end
  end

  assign res_o.valid   = v3_q;
  assign res_o.sq_dist = dist_q;
  assign res_o.age     = age3_q;

endmodule

@@ hw/rtl/keypoint_crowding_filter_unit.sv @@
// ----------------------------------------------------------------------------
// keypoint_crowding_filter_unit
// Drops tracked keypoints that crowd older survivors of the same frame.
// ----------------------------------------------------------------------------
// A keypoint word is compared with every survivor already stored for the
// frame, one survivor per cycle, through a single pipelined distance unit fed
// by the survivor memory's one read port. A valid point against K stored
// survivors runs until every distance returns or it is removed early; an
// invalid slot or a point arriving at an empty store reads none. The block
// holds in_stall_o high while it works on a word; the result word sits in an
// output register, so the next word may be taken while a result waits. The
// survivor memory needs no clearing: only entries below the survivor count
// are read, and frame_last resets that count after the word's result.
// ----------------------------------------------------------------------------
module keypoint_crowding_filter_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Keypoint input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [kcf_pkg::COORD_W-1:0]        pos_x_i,
  input  logic [kcf_pkg::COORD_W-1:0]        pos_y_i,
  input  logic [kcf_pkg::COORD_W-1:0]        age_frames_i,
  input  logic                               slot_valid_i,
  input  logic                               frame_last_i,
  // Result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               remove_point_o,
  output logic [kcf_pkg::KEPT_COUNT_W-1:0]   kept_count_o,
  // Configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [kcf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [kcf_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [kcf_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import kcf_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers
  logic [DIST_W-1:0] near_sq_q, crowd_sq_q;
  logic              cfg_wr;

  // Sequencer
  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic [CNT_W-1:0]  proc_q, proc_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [1:0]        near_cnt_q, near_cnt_d;
  logic [3:0]        crowd_cnt_q, crowd_cnt_d;
  logic              removed_q, removed_d;

  // Latched item
  logic [COORD_W-1:0] px_q, py_q, age_q;
  logic               slot_valid_q, last_q;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               out_remove_q, out_remove_d;
  logic [CNT_W-1:0]   out_count_q, out_count_d;

  // Datapath
  logic               accept;
  logic               issue_en;
  logic               hit;
  logic               last_res;
  logic               near_in, crowd_in, close_in;
  logic [1:0]         near_new;
  logic [3:0]         crowd_new;
  logic               out_free;
  logic               keep;
  logic [CNT_W-1:0]   total_new;
  kept_entry_t        rd_entry;
  logic               rd_valid;
  kept_entry_t        wr_entry;
  logic               wr_en;
  dist_res_t          res;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_sq_q  <= NEAR_RADIUS_SQ_RST;
      crowd_sq_q <= CROWD_RADIUS_SQ_RST;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_CROWD_RADIUS_SQ) begin
        crowd_sq_q <= pwdata[DIST_W-1:0];
      end else begin
        near_sq_q <= pwdata[DIST_W-1:0];
      end
    end
  end

  assign prdata = (paddr[3] == REG_CROWD_RADIUS_SQ) ? CFG_DATA_W'(crowd_sq_q)
                                                    : CFG_DATA_W'(near_sq_q);

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Neighbour counting and removal decision on each returned distance
  assign near_in   = res.sq_dist < near_sq_q;
  assign crowd_in  = res.sq_dist < crowd_sq_q;
  assign close_in  = res.sq_dist < ONE_PIXEL_SQ;
  assign near_new  = (near_cnt_q == NEAR_LIMIT) ? near_cnt_q : near_cnt_q + 2'(near_in);
  assign crowd_new = (crowd_cnt_q == CROWD_LIMIT) ? crowd_cnt_q
                                                  : crowd_cnt_q + 4'(crowd_in);
  assign hit = res.valid && (state_q == ST_RUN) && (age_q < res.age) &&
               (close_in || (near_new == NEAR_LIMIT) || (crowd_new == CROWD_LIMIT));
  assign last_res = res.valid && (CNT_W'(proc_q + 1'b1) == total_q);

  // One store read per cycle until every survivor is issued or a hit removes the point
  assign issue_en = (state_q == ST_RUN) && (issue_q < total_q) && !hit;

  // Append on survival while there is room
  assign keep      = slot_valid_q && !removed_q && (total_q < CNT_W'(MAX_POINTS));
  assign total_new = total_q + CNT_W'(keep);
  assign wr_en     = (state_q == ST_DONE) && out_free && keep;
  assign wr_entry  = '{x: px_q, y: py_q, age: age_q};

  // Next state
  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    proc_d       = proc_q;
    total_d      = total_q;
    near_cnt_d   = near_cnt_q;
    crowd_cnt_d  = crowd_cnt_q;
    removed_d    = removed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_remove_d = out_remove_q;
    out_count_d  = out_count_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          issue_d     = '0;
          proc_d      = '0;
          near_cnt_d  = '0;
          crowd_cnt_d = '0;
          removed_d   = 1'b0;
          state_d     = (slot_valid_i && (total_q != '0)) ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (issue_en) begin
          issue_d = issue_q + 1'b1;
        end
        if (res.valid) begin
          proc_d      = proc_q + 1'b1;
          near_cnt_d  = near_new;
          crowd_cnt_d = crowd_new;
          if (hit) begin
            removed_d = 1'b1;
            state_d   = ST_DONE;
          end else if (last_res) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_remove_d = removed_q;
          out_count_d  = total_new;
          total_d      = last_q ? '0 : total_new;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      proc_q      <= '0;
      total_q     <= '0;
      near_cnt_q  <= '0;
      crowd_cnt_q <= '0;
      removed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      proc_q      <= proc_d;
      total_q     <= total_d;
      near_cnt_q  <= near_cnt_d;
      crowd_cnt_q <= crowd_cnt_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q         <= pos_x_i;
      py_q         <= pos_y_i;
      age_q        <= age_frames_i;
      slot_valid_q <= slot_valid_i;
      last_q       <= frame_last_i;
    end
    out_remove_q <= out_remove_d;
    out_count_q  <= out_count_d;
  end

  // Survivor memory
  kcf_store #(
    .MAX_POINTS (MAX_POINTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (total_q[IDX_W-1:0]),
    .wr_data_i  (wr_entry),
    .rd_en_i    (issue_en),
    .rd_addr_i  (issue_q[IDX_W-1:0]),
    .flush_i    (hit),
    .rd_data_o  (rd_entry),
    .rd_valid_o (rd_valid)
  );

  // Shared distance unit
  kcf_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (hit),
    .valid_i (rd_valid),
    .ref_x_i (px_q),
    .ref_y_i (py_q),
    .entry_i (rd_entry),
    .res_o   (res)
  );

  // Outputs
  assign out_valid_o    = out_valid_q;
  assign remove_point_o = out_remove_q;
  assign kept_count_o   = KEPT_COUNT_W'(out_count_q);

endmodule

@@ hw/rtl/kcf_checker.sv @@
// ----------------------------------------------------------------------------
// kcf_checker
// Port-level checks of the keypoint crowding filter, bound to the top level.
// ----------------------------------------------------------------------------
module kcf_checker #(
  parameter int MAX_POINTS = 64
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             remove_point_o,
  input logic [kcf_pkg::KEPT_COUNT_W-1:0] kept_count_o,
  input logic                             pready
);
  import kcf_pkg::*;

  // A result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(remove_point_o) && $stable(kept_count_o))
    else $error("result word changed while stalled");

  // Survivor count never exceeds the store depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kept_count_o <= KEPT_COUNT_W'(MAX_POINTS)))
    else $error("kept count beyond store depth");

  // One word at a time: busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind keypoint_crowding_filter_unit kcf_checker #(
  .MAX_POINTS (MAX_POINTS)
) u_kcf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .remove_point_o (remove_point_o),
  .kept_count_o   (kept_count_o),
  .pready         (pready)
);
